// File: rtl/cseg_pkg.sv
// Shared widths, queue entry type and constants for the circle/segment test.
// Used by cseg_front, cseg_queue, cseg_back and circle_segment_intersect.
package cseg_pkg;

   localparam int COORD_BITS = 16;
   localparam int DIFF_W     = COORD_BITS + 1;
   localparam int PROD_W     = 2 * DIFF_W;
   localparam int MAG_W      = 2 * COORD_BITS + 1;
   localparam int LIN_W      = PROD_W + 2;
   localparam int SPLIT_LO   = (MAG_W + 1) / 2;
   localparam int SPLIT_HI   = MAG_W - SPLIT_LO;
   localparam int WIDE_W     = 2 * MAG_W;
   localparam int QDEPTH     = 4;
   localparam int QPTR_W     = $clog2(QDEPTH);
   localparam int REQ_BITS   = 7 * COORD_BITS;
   localparam int REQ_W      = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_W      = 8;

   typedef struct packed {
      logic [MAG_W-1:0] h_mag;
      logic [MAG_W-1:0] c_mag;
      logic [MAG_W-1:0] a_len;
      logic             c_pos;
      logic             pre_hit;
   } cls_type;

endpackage

// File: rtl/cseg_front.sv
// Front pipeline: differences, products, quadratic terms and root-range tests.
// Depends on cseg_pkg; feeds cls_type entries into cseg_queue.
module cseg_front import cseg_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [COORD_BITS-1:0] center_x,
   input  logic [COORD_BITS-1:0] center_y,
   input  logic [COORD_BITS-1:0] radius,
   input  logic [COORD_BITS-1:0] seg_start_x,
   input  logic [COORD_BITS-1:0] seg_start_y,
   input  logic [COORD_BITS-1:0] seg_end_x,
   input  logic [COORD_BITS-1:0] seg_end_y,
   input  logic                  q_full,
   output logic                  q_push,
   output cls_type               q_entry
);

   logic advance;
   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;

   logic signed [DIFF_W-1:0] dx_ff, dx_in, dy_ff, dy_in, fx_ff, fx_in, fy_ff, fy_in;
   logic [COORD_BITS-1:0]    r_ff, r_in;

   logic signed [PROD_W-1:0] dxx_ff, dxx_in, dyy_ff, dyy_in;
   logic signed [PROD_W-1:0] fxd_ff, fxd_in, fyd_ff, fyd_in;
   logic signed [PROD_W-1:0] fxx_ff, fxx_in, fyy_ff, fyy_in, rr_ff, rr_in;
   logic [2*COORD_BITS-1:0]  rsq;

   logic signed [PROD_W-1:0] a_sum, h_ff, h_in, c_ff, c_in;
   logic [MAG_W-1:0]         a_ff, a_in;

   logic signed [PROD_W-1:0] h_abs, c_abs;
   logic [MAG_W-1:0]         hm, cm;
   logic                     h_neg, h_pos, c_neg, c_pos, h_le0, h_ge0, c_le0, c_ge0;
   logic signed [LIN_W-1:0]  a_l, c_l, hm2_l, t_lo, t_hi;
   logic                     hit1, hit2, sec_ok;

   assign advance  = !v3_ff || !q_full;
   assign in_ready = advance;
   assign q_push   = v3_ff && !q_full;

   // difference stage
   assign v1_in = in_valid;
   assign dx_in = $signed({1'b0, seg_end_x}) - $signed({1'b0, seg_start_x});
   assign dy_in = $signed({1'b0, seg_end_y}) - $signed({1'b0, seg_start_y});
   assign fx_in = $signed({1'b0, seg_start_x}) - $signed({1'b0, center_x});
   assign fy_in = $signed({1'b0, seg_start_y}) - $signed({1'b0, center_y});
   assign r_in  = radius;

   // product stage
   assign v2_in  = v1_ff;
   assign dxx_in = dx_ff * dx_ff;
   assign dyy_in = dy_ff * dy_ff;
   assign fxd_in = fx_ff * dx_ff;
   assign fyd_in = fy_ff * dy_ff;
   assign fxx_in = fx_ff * fx_ff;
   assign fyy_in = fy_ff * fy_ff;
   assign rsq    = r_ff * r_ff;
   assign rr_in  = $signed({{(PROD_W-2*COORD_BITS){1'b0}}, rsq});

   // sum stage
   assign v3_in = v2_ff;
   assign a_sum = dxx_ff + dyy_ff;
   assign a_in  = a_sum[MAG_W-1:0];
   assign h_in  = fxd_ff + fyd_ff;
   assign c_in  = fxx_ff + fyy_ff - rr_ff;

   // classify: root range tests reduced to linear compares
   always_comb begin
      h_neg = h_ff[PROD_W-1];
      h_pos = !h_neg && (h_ff != '0);
      c_neg = c_ff[PROD_W-1];
      c_pos = !c_neg && (c_ff != '0);
      h_le0 = !h_pos;
      h_ge0 = !h_neg;
      c_le0 = !c_pos;
      c_ge0 = !c_neg;
      h_abs = h_neg ? -h_ff : h_ff;
      c_abs = c_neg ? -c_ff : c_ff;
      hm    = h_abs[MAG_W-1:0];
      cm    = c_abs[MAG_W-1:0];
      a_l   = $signed({{(LIN_W-MAG_W){1'b0}}, a_ff});
      c_l   = $signed({{(LIN_W-PROD_W){c_ff[PROD_W-1]}}, c_ff});
      hm2_l = $signed({{(LIN_W-MAG_W-1){1'b0}}, hm, 1'b0});
      t_lo  = hm2_l - a_l - c_l;
      t_hi  = hm2_l + a_l + c_l;
      hit1  = h_le0 && c_ge0 && ((hm <= a_ff) || !t_lo[LIN_W-1]);
      sec_ok = h_le0 || c_le0;
      if (h_ge0) begin
         hit2 = sec_ok && !t_hi[LIN_W-1];
      end else begin
         hit2 = sec_ok && (a_ff >= hm) && (t_lo[LIN_W-1] || (t_lo == '0));
      end
      q_entry.h_mag   = hm;
      q_entry.c_mag   = cm;
      q_entry.a_len   = a_ff;
      q_entry.c_pos   = c_pos;
      q_entry.pre_hit = (a_ff != '0) && (hit1 || hit2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dx_ff  <= dx_in;
         dy_ff  <= dy_in;
         fx_ff  <= fx_in;
         fy_ff  <= fy_in;
         r_ff   <= r_in;
         dxx_ff <= dxx_in;
         dyy_ff <= dyy_in;
         fxd_ff <= fxd_in;
         fyd_ff <= fyd_in;
         fxx_ff <= fxx_in;
         fyy_ff <= fyy_in;
         rr_ff  <= rr_in;
         a_ff   <= a_in;
         h_ff   <= h_in;
         c_ff   <= c_in;
      end
   end

endmodule

// File: rtl/cseg_queue.sv
// Small register queue of classified items between front and back.
// Depends on cseg_pkg for cls_type and depth.
module cseg_queue import cseg_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cls_type push_data,
   output logic    full,
   input  logic    pop,
   output cls_type pop_data,
   output logic    empty
);

   cls_type           mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   cnt_ff, cnt_in;

   assign full     = (cnt_ff == (QPTR_W+1)'(QDEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      case ({push, pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) !(pop && empty))
      else $error("queue pop while empty");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (QPTR_W+1)'(QDEPTH))
      else $error("queue count beyond depth");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (cnt_ff == $past(cnt_ff) + 1'b1))
      else $error("queue count did not advance on push");
`endif

endmodule

// File: rtl/cseg_back.sv
// Back pipeline: split products for h^2 and a*|c|, discriminant sign, result register.
// Depends on cseg_pkg; drains cseg_queue.
module cseg_back import cseg_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    q_empty,
   output logic    q_pop,
   input  cls_type q_entry,
   output logic    out_valid,
   input  logic    out_ready,
   output logic    out_hit
);

   logic advance;
   logic b1_v_ff, b1_v_in, out_v_ff, out_v_in;
   logic hit_ff, hit_in;

   logic [SPLIT_LO-1:0] hm_lo, a_lo, cm_lo;
   logic [SPLIT_HI-1:0] hm_hi, a_hi, cm_hi;

   logic [2*SPLIT_LO-1:0]        hh_ll_ff, hh_ll_in, ac_ll_ff, ac_ll_in;
   logic [SPLIT_LO+SPLIT_HI-1:0] hh_lh_ff, hh_lh_in, ac_lh_ff, ac_lh_in, ac_hl_ff, ac_hl_in;
   logic [2*SPLIT_HI-1:0]        hh_hh_ff, hh_hh_in, ac_hh_ff, ac_hh_in;
   logic                         c_pos_ff, pre_ff;

   logic [WIDE_W-1:0] h_sq, a_c;

   assign advance   = !out_v_ff || out_ready;
   assign q_pop     = advance && !q_empty;
   assign b1_v_in   = !q_empty;
   assign out_v_in  = b1_v_ff;
   assign out_valid = out_v_ff;
   assign out_hit   = hit_ff;

   // partial products
   assign hm_lo = q_entry.h_mag[SPLIT_LO-1:0];
   assign hm_hi = q_entry.h_mag[MAG_W-1:SPLIT_LO];
   assign a_lo  = q_entry.a_len[SPLIT_LO-1:0];
   assign a_hi  = q_entry.a_len[MAG_W-1:SPLIT_LO];
   assign cm_lo = q_entry.c_mag[SPLIT_LO-1:0];
   assign cm_hi = q_entry.c_mag[MAG_W-1:SPLIT_LO];

   assign hh_ll_in = hm_lo * hm_lo;
   assign hh_lh_in = hm_lo * hm_hi;
   assign hh_hh_in = hm_hi * hm_hi;
   assign ac_ll_in = a_lo * cm_lo;
   assign ac_lh_in = a_lo * cm_hi;
   assign ac_hl_in = a_hi * cm_lo;
   assign ac_hh_in = a_hi * cm_hi;

   // recombine and clear the hit of items whose discriminant is negative
   assign h_sq = WIDE_W'(hh_ll_ff) + (WIDE_W'(hh_lh_ff) << (SPLIT_LO + 1))
               + (WIDE_W'(hh_hh_ff) << (2 * SPLIT_LO));
   assign a_c  = WIDE_W'(ac_ll_ff) + ((WIDE_W'(ac_lh_ff) + WIDE_W'(ac_hl_ff)) << SPLIT_LO)
               + (WIDE_W'(ac_hh_ff) << (2 * SPLIT_LO));
   assign hit_in = pre_ff && !(c_pos_ff && (h_sq < a_c));

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (advance) begin
         b1_v_ff  <= b1_v_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         hh_ll_ff <= hh_ll_in;
         hh_lh_ff <= hh_lh_in;
         hh_hh_ff <= hh_hh_in;
         ac_ll_ff <= ac_ll_in;
         ac_lh_ff <= ac_lh_in;
         ac_hl_ff <= ac_hl_in;
         ac_hh_ff <= ac_hh_in;
         c_pos_ff <= q_entry.c_pos;
         pre_ff   <= q_entry.pre_hit;
         hit_ff   <= hit_in;
      end
   end

`ifndef SYNTHESIS
   a_hit_needs_pre: assert property (@(posedge clock) disable iff (reset)
      (advance && b1_v_ff && !pre_ff) |=> !hit_ff)
      else $error("hit without passing range tests");
   a_stage_refill: assert property (@(posedge clock) disable iff (reset)
      (advance && b1_v_ff) |=> out_v_ff)
      else $error("result lost between back stages");
   a_pop_on_advance: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (advance && !q_empty))
      else $error("queue popped while back stage stalled");
`endif

endmodule

// File: rtl/circle_segment_intersect.sv
// Circle versus line segment crossing test, top level.
// Depends on cseg_pkg, cseg_front, cseg_queue and cseg_back.
//
// req channel: one circle and one segment per transfer, seven coordinate
// fields packed in req_tdata. rsp channel: one transfer per request, hit in
// rsp_tdata bit 0, in request order.
// Throughput: one item per cycle while rsp_tready stays high; the front
// pipeline, the queue and the back pipeline each take one item a cycle.
// A request passes the three front stages, a queue write and the back
// product stage, and its result is held in the output register.
// When the receiver stalls, the back pipeline holds, the four-entry queue
// fills, and then req_tready drops; no item is lost or repeated.
// Reset clears all valid bits and queue pointers; the block is ready in the
// first cycle after reset.
module circle_segment_intersect import cseg_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // center_x, center_y, radius, seg_start_x, seg_start_y, seg_end_x, seg_end_y
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // hit, then zero fill
   output logic [RSP_W-1:0] rsp_tdata
);

   logic    q_full, q_empty, q_push, q_pop, hit;
   cls_type push_entry, pop_entry;

   cseg_front u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .center_x    (req_tdata[0*COORD_BITS +: COORD_BITS]),
      .center_y    (req_tdata[1*COORD_BITS +: COORD_BITS]),
      .radius      (req_tdata[2*COORD_BITS +: COORD_BITS]),
      .seg_start_x (req_tdata[3*COORD_BITS +: COORD_BITS]),
      .seg_start_y (req_tdata[4*COORD_BITS +: COORD_BITS]),
      .seg_end_x   (req_tdata[5*COORD_BITS +: COORD_BITS]),
      .seg_end_y   (req_tdata[6*COORD_BITS +: COORD_BITS]),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_entry     (push_entry)
   );

   cseg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_entry),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (pop_entry),
      .empty     (q_empty)
   );

   cseg_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .q_entry   (pop_entry),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_hit   (hit)
   );

   assign rsp_tdata = {{(RSP_W-1){1'b0}}, hit};

endmodule

// File: tb/sv/circle_segment_intersect_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for circle_segment_intersect: a directed table, then random circle and
// segment pairs, checked against an exact wide-integer crossing predictor under random idles.
// Depends on cseg_pkg and the circle_segment_intersect RTL.
module circle_segment_intersect_tb;
   import cseg_pkg::*;

   typedef logic [COORD_BITS-1:0] coord_t;

   // packed so that center_x sits in the lowest bits of req_tdata
   typedef struct packed {
      coord_t end_y;
      coord_t end_x;
      coord_t start_y;
      coord_t start_x;
      coord_t rad;
      coord_t ctr_y;
      coord_t ctr_x;
   } req_t;

   typedef struct packed {
      int cx, cy, r, x1, y1, x2, y2;
      bit known;
      bit want;
   } vec_t;

   localparam int MAX_COORD  = (1 << COORD_BITS) - 1;
   localparam int N_RANDOM   = 1500;
   localparam int CALM_FIRST = 400;
   localparam int CALM_LAST  = 699;
   localparam int DRAIN_AT   = 1000;
   localparam int N_DIR      = 22;

   localparam vec_t DIR_VECS [N_DIR] = '{
      '{0, 0, 0, 0, 0, 0, 0, 1, 0},
      '{65535, 65535, 65535, 65535, 65535, 65535, 65535, 1, 0},
      '{100, 100, 10, 110, 100, 110, 100, 1, 0},
      '{100, 100, 10, 0, 0, 200, 0, 1, 0},
      '{1000, 1000, 500, 900, 1000, 1100, 1000, 1, 0},
      '{100, 100, 10, 0, 110, 200, 110, 1, 1},
      '{100, 100, 10, 200, 110, 300, 110, 1, 0},
      '{100, 100, 10, 110, 100, 200, 100, 1, 1},
      '{100, 100, 10, 0, 100, 90, 100, 1, 1},
      '{100, 100, 10, 0, 100, 200, 100, 1, 1},
      '{100, 100, 10, 0, 100, 89, 100, 1, 0},
      '{100, 100, 10, 100, 100, 200, 100, 1, 1},
      '{50, 50, 0, 0, 0, 100, 100, 0, 0},
      '{0, 0, 65535, 0, 0, 65535, 65535, 0, 0},
      '{65535, 65535, 65535, 0, 0, 65535, 0, 0, 0},
      '{0, 65535, 65535, 65535, 0, 0, 0, 0, 0},
      '{0, 0, 0, 1, 0, 2, 0, 0, 0},
      '{43690, 21845, 21845, 43690, 21845, 21845, 43690, 0, 0},
      '{21845, 43690, 43690, 21845, 43690, 43690, 21845, 0, 0},
      '{500, 500, 100, 500, 0, 500, 65535, 1, 1},
      '{500, 500, 100, 600, 500, 500, 500, 1, 1},
      '{0, 0, 65535, 65535, 65535, 65535, 0, 0, 0}
   };

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   // center_x, center_y, radius, seg_start_x, seg_start_y, seg_end_x, seg_end_y
   logic [REQ_W-1:0] req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   // hit, then zero fill
   logic [RSP_W-1:0] rsp_tdata;

   bit given_known;
   bit given_want;
   bit calm;
   bit want_hit;
   bit pending_hits [$];
   int errors;

   circle_segment_intersect dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #2 clock = ~clock;

   function automatic bit [127:0] square(input longint k);
      bit [127:0] kk;
      kk = k;
      return kk * kk;
   endfunction

   function automatic bit crosses_boundary(input req_t q);
      longint cx, cy, sx, sy, ex, ey, rr, dx, dy, fx, fy, a, h, c, hm, cm;
      bit [127:0] h2, ac, av, cv, disc;
      bit hit;
      cx = q.ctr_x;
      cy = q.ctr_y;
      rr = q.rad;
      sx = q.start_x;
      sy = q.start_y;
      ex = q.end_x;
      ey = q.end_y;
      dx = ex - sx;
      dy = ey - sy;
      fx = sx - cx;
      fy = sy - cy;
      a = dx * dx + dy * dy;
      h = fx * dx + fy * dy;
      c = fx * fx + fy * fy - rr * rr;
      hm = (h < 0) ? -h : h;
      cm = (c < 0) ? -c : c;
      hit = 1'b0;
      if (a == 0) return 1'b0;
      h2 = square(hm);
      av = a;
      cv = cm;
      ac = av * cv;
      if (c <= 0) begin
         disc = h2 + ac;
      end else begin
         if (h2 < ac) return 1'b0;
         disc = h2 - ac;
      end
      if (h <= 0 && disc <= square(hm)) begin
         if (hm <= a || disc >= square(hm - a)) hit = 1'b1;
      end
      if (h <= 0 || disc >= square(hm)) begin
         if (h >= 0) begin
            if (disc <= square(hm + a)) hit = 1'b1;
         end else if (a >= hm) begin
            if (disc <= square(a - hm)) hit = 1'b1;
         end
      end
      return hit;
   endfunction

   function automatic int clip(input int v);
      return (v < 0) ? 0 : ((v > MAX_COORD) ? MAX_COORD : v);
   endfunction

   function automatic int near(input int span);
      return int'($urandom_range(0, 4 * span)) - 2 * span;
   endfunction

   function automatic req_t make_req(input int cx, input int cy, input int r, input int x1,
                                     input int y1, input int x2, input int y2);
      req_t q;
      q.ctr_x   = coord_t'(cx);
      q.ctr_y   = coord_t'(cy);
      q.rad     = coord_t'(r);
      q.start_x = coord_t'(x1);
      q.start_y = coord_t'(y1);
      q.end_x   = coord_t'(x2);
      q.end_y   = coord_t'(y2);
      return q;
   endfunction

   task automatic random_pair(output req_t q);
      int mode, span, cx, cy, r, x1, y1, x2, y2;
      mode = $urandom_range(0, 9);
      span = 1 << $urandom_range(1, COORD_BITS - 1);
      cx = $urandom_range(1000, MAX_COORD - 1000);
      cy = $urandom_range(1000, MAX_COORD - 1000);
      r  = $urandom_range(1, 1000);
      x1 = clip(cx + near(2000));
      y1 = clip(cy + near(2000));
      x2 = clip(cx + near(2000));
      y2 = clip(cy + near(2000));
      case (mode)
         0, 1: begin
            cx = $urandom_range(0, MAX_COORD);
            cy = $urandom_range(0, MAX_COORD);
            r  = $urandom_range(0, MAX_COORD);
            x1 = $urandom_range(0, MAX_COORD);
            y1 = $urandom_range(0, MAX_COORD);
            x2 = $urandom_range(0, MAX_COORD);
            y2 = $urandom_range(0, MAX_COORD);
         end
         6: begin
            case ($urandom_range(0, 3))
               0: begin x1 = cx + r; y1 = cy; end
               1: begin x1 = cx - r; y1 = cy; end
               2: begin x1 = cx; y1 = cy + r; end
               default: begin x1 = cx; y1 = cy - r; end
            endcase
            if ($urandom_range(0, 1) == 1) begin
               {x1, x2} = {x2, x1};
               {y1, y2} = {y2, y1};
            end
         end
         7: begin
            y1 = ($urandom_range(0, 1) == 1) ? cy + r : cy - r;
            y2 = y1;
            x1 = clip(cx + near(1000));
            x2 = clip(cx + near(1000));
         end
         8: begin
            x1 = $urandom_range(0, MAX_COORD);
            y1 = $urandom_range(0, MAX_COORD);
            x2 = x1;
            y2 = y1;
            cx = clip(x1 + near(span));
            cy = clip(y1 + near(span));
            r  = $urandom_range(0, span);
         end
         9: begin
            cx = $urandom_range(0, 15);
            cy = $urandom_range(0, 15);
            r  = $urandom_range(0, 15);
            x1 = $urandom_range(0, 15);
            y1 = $urandom_range(0, 15);
            x2 = $urandom_range(0, 15);
            y2 = $urandom_range(0, 15);
         end
         default: begin
            cx = $urandom_range(0, MAX_COORD);
            cy = $urandom_range(0, MAX_COORD);
            r  = $urandom_range(0, span);
            x1 = clip(cx + near(span));
            y1 = clip(cy + near(span));
            x2 = clip(cx + near(span));
            y2 = clip(cy + near(span));
         end
      endcase
      q = make_req(cx, cy, r, x1, y1, x2, y2);
   endtask

   // enter and leave at a falling edge
   task automatic send(input req_t q, input bit known, input bit want, input bit may_idle);
      while (may_idle && $urandom_range(0, 99) < 15) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid  = 1'b1;
      req_tdata   = q;
      given_known = known;
      given_want  = want;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      rsp_tready = calm || ($urandom_range(0, 99) >= 15);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            pending_hits.push_back(given_known ? given_want : crosses_boundary(req_t'(req_tdata)));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_hits.size() == 0) begin
               $error("result transfer with no request waiting: rsp_tdata %0h", rsp_tdata);
               errors++;
            end else begin
               want_hit = pending_hits.pop_front();
               if (rsp_tdata[0] !== want_hit) begin
                  $error("hit: expected %0d, actual %0b", want_hit, rsp_tdata[0]);
                  errors++;
               end
               if (rsp_tdata[RSP_W-1:1] !== '0) begin
                  $error("rsp_tdata fill: expected 0, actual %0h", rsp_tdata[RSP_W-1:1]);
                  errors++;
               end
            end
         end
      end
   end

   initial begin
      req_t q;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      foreach (DIR_VECS[i]) begin
         send(make_req(DIR_VECS[i].cx, DIR_VECS[i].cy, DIR_VECS[i].r, DIR_VECS[i].x1,
                       DIR_VECS[i].y1, DIR_VECS[i].x2, DIR_VECS[i].y2),
              DIR_VECS[i].known, DIR_VECS[i].want, 1'b1);
      end
      for (int n = 0; n < N_RANDOM; n++) begin
         if (n == DRAIN_AT) begin
            req_tvalid = 1'b0;
            while (pending_hits.size() != 0) @(negedge clock);
         end
         calm = (n >= CALM_FIRST && n <= CALM_LAST);
         random_pair(q);
         send(q, 1'b0, 1'b0, !calm);
      end
      req_tvalid = 1'b0;
      calm = 1'b0;
      while (pending_hits.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #1_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
